@@ design/pft_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Planar frame transform package
// Shared constants, the arctangent table, the trig sequencer states and the
// bundle that carries sine and cosine from the trig unit to the datapath.
// ----------------------------------------------------------------------------
package pft_pkg;

	localparam int COORD_WIDTH_DEF  = 32;
	localparam int ANGLE_WIDTH_DEF  = 18;
	localparam int CORDIC_STEPS_DEF = 16;

	// Configuration register indexes.
	localparam int              CFG_INDEX_WIDTH  = 2;
	localparam logic [1:0]      REG_BASE_X       = 2'd0;
	localparam logic [1:0]      REG_BASE_Y       = 2'd1;
	localparam logic [1:0]      REG_BASE_HEADING = 2'd2;

	// Q30 trig values: CORDIC state width and magnitude width.
	localparam int FRAC_BITS   = 30;
	localparam int CORDIC_XW   = 32;
	localparam int TRIG_WIDTH  = 31;

	localparam longint Q30_PI      = 64'sd3373259426;
	localparam longint Q30_HALF_PI = 64'sd1686629713;
	localparam longint Q30_TWO_PI  = 64'sd6746518852;
	localparam longint Q30_GAIN    = 64'sd652032874;

	localparam int ATAN_LEN   = 24;
	localparam int STEP_WIDTH = $clog2(ATAN_LEN);

	localparam logic [29:0] ATAN_Q30 [ATAN_LEN] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
		30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
		30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
		30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048,
		30'd1024,      30'd512,       30'd256,       30'd128
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_REDUCE,
		ST_FOLD,
		ST_HALF,
		ST_ROT,
		ST_DONE
	} pft_state_t;

	typedef struct packed {
		logic                  ready;
		logic [TRIG_WIDTH-1:0] cos_mag;
		logic                  cos_neg;
		logic [TRIG_WIDTH-1:0] sin_mag;
		logic                  sin_neg;
	} pft_trig_t;

endpackage
`default_nettype wire

@@ design/pft_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Planar frame transform stream interfaces
// Valid/ready channels for the pose items going in and the results coming out.
// ----------------------------------------------------------------------------
interface pft_in_if #(
	parameter int COORD_WIDTH = 32,
	parameter int ANGLE_WIDTH = 18
);
	logic                          valid;
	logic                          ready;
	logic                          cmd;
	logic signed [COORD_WIDTH-1:0] in_x;
	logic signed [COORD_WIDTH-1:0] in_y;
	logic signed [ANGLE_WIDTH-2:0] in_heading;

	modport source (output valid, cmd, in_x, in_y, in_heading, input ready);
	modport sink (input valid, cmd, in_x, in_y, in_heading, output ready);
endinterface

interface pft_out_if #(
	parameter int COORD_WIDTH = 32,
	parameter int ANGLE_WIDTH = 18
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] out_x;
	logic signed [COORD_WIDTH-1:0] out_y;
	logic signed [ANGLE_WIDTH-1:0] out_heading;
	logic                          saturated;

	modport source (output valid, out_x, out_y, out_heading, saturated, input ready);
	modport sink (input valid, out_x, out_y, out_heading, saturated, output ready);
endinterface
`default_nettype wire

@@ design/pft_sincos.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Planar frame transform trig unit
// Reduces the base heading and runs a rotation-mode CORDIC, one step per cycle.
// ----------------------------------------------------------------------------
module pft_sincos #(
	parameter int ANGLE_WIDTH  = pft_pkg::ANGLE_WIDTH_DEF,
	parameter int CORDIC_STEPS = pft_pkg::CORDIC_STEPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [ANGLE_WIDTH-2:0] heading,
	output pft_pkg::pft_trig_t            trig
);
	import pft_pkg::*;

	localparam int HW    = ANGLE_WIDTH - 1;
	localparam int ZW    = (ANGLE_WIDTH + 17 > 36) ? ANGLE_WIDTH + 17 : 36;
	localparam int NSTEP = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
	localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(NSTEP - 1);

	localparam logic signed [ZW-1:0] Z_PI       = ZW'(Q30_PI);
	localparam logic signed [ZW-1:0] Z_NEG_PI   = ZW'(-Q30_PI);
	localparam logic signed [ZW-1:0] Z_HALF     = ZW'(Q30_HALF_PI);
	localparam logic signed [ZW-1:0] Z_NEG_HALF = ZW'(-Q30_HALF_PI);
	localparam logic signed [ZW-1:0] Z_TWO_PI   = ZW'(Q30_TWO_PI);
	localparam logic signed [ZW-1:0] Z_NEG_2PI  = ZW'(-Q30_TWO_PI);
	localparam logic signed [CORDIC_XW-1:0] X_GAIN = CORDIC_XW'(Q30_GAIN);

	pft_state_t                   state_q, state_d;
	logic [STEP_WIDTH-1:0]        step_q;
	logic                         flip_q;
	logic signed [ZW-1:0]         z_q;
	logic signed [CORDIC_XW-1:0]  x_q, y_q;
	logic signed [CORDIC_XW-1:0]  dx, dy, x_abs, y_abs;
	logic signed [ZW-1:0]         atan_z;
	logic                         z_ge_2pi, z_le_m2pi;
	logic [TRIG_WIDTH-1:0]        cos_mag_q, sin_mag_q;
	logic                         cos_neg_q, sin_neg_q;

	assign z_ge_2pi  = (z_q >= Z_TWO_PI);
	assign z_le_m2pi = (z_q <= Z_NEG_2PI);
	assign dx        = y_q >>> step_q;
	assign dy        = x_q >>> step_q;
	assign atan_z    = ZW'(ATAN_Q30[step_q]);
	assign x_abs     = x_q[CORDIC_XW-1] ? -x_q : x_q;
	assign y_abs     = y_q[CORDIC_XW-1] ? -y_q : y_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   state_d = ST_IDLE;
			ST_LOAD:   state_d = ST_REDUCE;
			ST_REDUCE: if (!z_ge_2pi && !z_le_m2pi) state_d = ST_FOLD;
			ST_FOLD:   state_d = ST_HALF;
			ST_HALF:   state_d = ST_ROT;
			ST_ROT:    if (step_q == LAST_STEP) state_d = ST_DONE;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
		if (start) state_d = ST_LOAD;
	end

	always_comb begin
		trig.ready   = (state_q == ST_IDLE);
		trig.cos_mag = cos_mag_q;
		trig.cos_neg = cos_neg_q;
		trig.sin_mag = sin_mag_q;
		trig.sin_neg = sin_neg_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_HALF) step_q <= '0;
			else if (state_q == ST_ROT) step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_LOAD: begin
				z_q <= {{(ZW - HW - 16){heading[HW-1]}}, heading, 16'b0};
			end
			ST_REDUCE: begin
				// Truncating remainder: walk toward zero until below one turn.
				if (z_ge_2pi) z_q <= z_q - Z_TWO_PI;
				else if (z_le_m2pi) z_q <= z_q + Z_TWO_PI;
			end
			ST_FOLD: begin
				if (z_q > Z_PI) z_q <= z_q - Z_TWO_PI;
				else if (z_q < Z_NEG_PI) z_q <= z_q + Z_TWO_PI;
			end
			ST_HALF: begin
				// Outside the right half plane, rotate by pi and negate at the end.
				if (z_q > Z_HALF) begin
					z_q    <= z_q - Z_PI;
					flip_q <= 1'b1;
				end else if (z_q < Z_NEG_HALF) begin
					z_q    <= z_q + Z_PI;
					flip_q <= 1'b1;
				end else begin
					flip_q <= 1'b0;
				end
				x_q <= X_GAIN;
				y_q <= '0;
			end
			ST_ROT: begin
				if (!z_q[ZW-1]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan_z;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan_z;
				end
			end
			ST_DONE: begin
				cos_mag_q <= x_abs[TRIG_WIDTH-1:0];
				cos_neg_q <= x_q[CORDIC_XW-1] ^ flip_q;
				sin_mag_q <= y_abs[TRIG_WIDTH-1:0];
				sin_neg_q <= y_q[CORDIC_XW-1] ^ flip_q;
			end
			default: begin
				z_q <= z_q;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ design/pft_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Planar frame transform rounding multiplier
// Magnitude times Q30 trig value in two partial products, rounded half away
// from zero to the coordinate format, then signed. Three register stages.
// ----------------------------------------------------------------------------
module pft_mul #(
	parameter int MAG_WIDTH = pft_pkg::COORD_WIDTH_DEF + 1
) (
	input  logic                             clk,
	input  logic                             ce,
	input  logic [MAG_WIDTH-1:0]             mag,
	input  logic [pft_pkg::TRIG_WIDTH-1:0]   trig_mag,
	input  logic                             neg,
	output logic signed [MAG_WIDTH+1:0]      term
);
	import pft_pkg::*;

	localparam int LOW  = (MAG_WIDTH + 1) / 2;
	localparam int HIGH = MAG_WIDTH - LOW;
	localparam int PW   = MAG_WIDTH + TRIG_WIDTH;
	localparam int QW   = PW - FRAC_BITS;
	localparam logic [PW-1:0] ROUND_HALF = PW'(1) << (FRAC_BITS - 1);

	logic [LOW+TRIG_WIDTH-1:0]    pp_lo_s3;
	logic [HIGH+TRIG_WIDTH-1:0]   pp_hi_s3;
	logic                         neg_s3, neg_s4;
	logic [PW-1:0]                full;
	logic [QW-1:0]                q_s4;
	logic signed [MAG_WIDTH+1:0]  q_ext;
	logic signed [MAG_WIDTH+1:0]  term_s5;

	assign full  = {pp_hi_s3, {LOW{1'b0}}} + PW'(pp_lo_s3) + ROUND_HALF;
	assign q_ext = {{(MAG_WIDTH + 2 - QW){1'b0}}, q_s4};
	assign term  = term_s5;

	always_ff @(posedge clk) begin
		if (ce) begin
			pp_lo_s3 <= mag[LOW-1:0] * trig_mag;
			pp_hi_s3 <= mag[MAG_WIDTH-1:LOW] * trig_mag;
			neg_s3   <= neg;
			q_s4     <= full[PW-1:FRAC_BITS];
			neg_s4   <= neg_s3;
			term_s5  <= neg_s4 ? -q_ext : q_ext;
		end
	end

endmodule
`default_nettype wire

@@ design/pft_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Planar frame transform datapath
// Seven-stage pipeline: operand select, magnitudes, four rounding products,
// three-input sums and saturation. All stages advance together on ce.
// ----------------------------------------------------------------------------
module pft_datapath #(
	parameter int COORD_WIDTH = pft_pkg::COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH = pft_pkg::ANGLE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          ce,
	input  logic                          accept,
	input  logic                          cmd,
	input  logic signed [COORD_WIDTH-1:0] in_x,
	input  logic signed [COORD_WIDTH-1:0] in_y,
	input  logic signed [ANGLE_WIDTH-2:0] in_heading,
	input  logic signed [COORD_WIDTH-1:0] base_x,
	input  logic signed [COORD_WIDTH-1:0] base_y,
	input  logic signed [ANGLE_WIDTH-2:0] base_heading,
	input  pft_pkg::pft_trig_t            trig,
	output logic                          valid,
	output logic signed [COORD_WIDTH-1:0] out_x,
	output logic signed [COORD_WIDTH-1:0] out_y,
	output logic signed [ANGLE_WIDTH-1:0] out_heading,
	output logic                          saturated
);
	import pft_pkg::*;

	localparam int MW = COORD_WIDTH + 1;
	localparam int TW = MW + 2;
	localparam int SW = COORD_WIDTH + 4;
	localparam int NS = 7;
	localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

	logic [NS:1]                   v_q;

	logic signed [MW-1:0]          a_s1, b_s1;
	logic signed [COORD_WIDTH-1:0] offx_s1, offy_s1;
	logic signed [ANGLE_WIDTH-1:0] head_s1;
	logic                          cmd_s1;

	logic [MW-1:0]                 ua_s2, ub_s2;
	logic                          n_ac_s2, n_bs_s2, n_bc_s2, n_as_s2;
	logic signed [COORD_WIDTH-1:0] offx_s2, offy_s2, offx_s3, offy_s3;
	logic signed [COORD_WIDTH-1:0] offx_s4, offy_s4, offx_s5, offy_s5;
	logic signed [ANGLE_WIDTH-1:0] head_s2, head_s3, head_s4, head_s5, head_s6, head_s7;

	logic signed [TW-1:0]          t_ac, t_bs, t_bc, t_as;
	logic signed [SW-1:0]          rx_s6, ry_s6;
	logic signed [COORD_WIDTH-1:0] x_s7, y_s7;
	logic                          sat_s7;

	logic signed [MW-1:0]          a_abs, b_abs;
	logic                          ovf_x, ovf_y;

	assign a_abs = a_s1[MW-1] ? -a_s1 : a_s1;
	assign b_abs = b_s1[MW-1] ? -b_s1 : b_s1;

	// In range only if the bits above the result's sign all agree with it.
	assign ovf_x = !((&rx_s6[SW-1:COORD_WIDTH-1]) || !(|rx_s6[SW-1:COORD_WIDTH-1]));
	assign ovf_y = !((&ry_s6[SW-1:COORD_WIDTH-1]) || !(|ry_s6[SW-1:COORD_WIDTH-1]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (ce) begin
			v_q <= {v_q[NS-1:1], accept};
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			// Local to world rotates the point itself; world to local first
			// takes the offset out and adds nothing back.
			cmd_s1  <= cmd;
			a_s1    <= cmd ? MW'(in_x) - MW'(base_x) : MW'(in_x);
			b_s1    <= cmd ? MW'(in_y) - MW'(base_y) : MW'(in_y);
			offx_s1 <= cmd ? '0 : base_x;
			offy_s1 <= cmd ? '0 : base_y;
			head_s1 <= cmd ? ANGLE_WIDTH'(in_heading) - ANGLE_WIDTH'(base_heading)
				: ANGLE_WIDTH'(base_heading) + ANGLE_WIDTH'(in_heading);

			ua_s2   <= a_abs;
			ub_s2   <= b_abs;
			n_ac_s2 <= a_s1[MW-1] ^ trig.cos_neg;
			n_bs_s2 <= b_s1[MW-1] ^ trig.sin_neg ^ ~cmd_s1;
			n_bc_s2 <= b_s1[MW-1] ^ trig.cos_neg;
			n_as_s2 <= a_s1[MW-1] ^ trig.sin_neg ^ cmd_s1;
			offx_s2 <= offx_s1;
			offy_s2 <= offy_s1;
			head_s2 <= head_s1;

			offx_s3 <= offx_s2;
			offy_s3 <= offy_s2;
			head_s3 <= head_s2;
			offx_s4 <= offx_s3;
			offy_s4 <= offy_s3;
			head_s4 <= head_s3;
			offx_s5 <= offx_s4;
			offy_s5 <= offy_s4;
			head_s5 <= head_s4;

			rx_s6   <= SW'(offx_s5) + SW'(t_ac) + SW'(t_bs);
			ry_s6   <= SW'(offy_s5) + SW'(t_bc) + SW'(t_as);
			head_s6 <= head_s5;

			x_s7    <= ovf_x ? (rx_s6[SW-1] ? C_MIN : C_MAX) : rx_s6[COORD_WIDTH-1:0];
			y_s7    <= ovf_y ? (ry_s6[SW-1] ? C_MIN : C_MAX) : ry_s6[COORD_WIDTH-1:0];
			sat_s7  <= ovf_x | ovf_y;
			head_s7 <= head_s6;
		end
	end

	pft_mul #(.MAG_WIDTH(MW)) u_mul_ac (
		.clk(clk), .ce(ce), .mag(ua_s2), .trig_mag(trig.cos_mag), .neg(n_ac_s2), .term(t_ac)
	);
	pft_mul #(.MAG_WIDTH(MW)) u_mul_bs (
		.clk(clk), .ce(ce), .mag(ub_s2), .trig_mag(trig.sin_mag), .neg(n_bs_s2), .term(t_bs)
	);
	pft_mul #(.MAG_WIDTH(MW)) u_mul_bc (
		.clk(clk), .ce(ce), .mag(ub_s2), .trig_mag(trig.cos_mag), .neg(n_bc_s2), .term(t_bc)
	);
	pft_mul #(.MAG_WIDTH(MW)) u_mul_as (
		.clk(clk), .ce(ce), .mag(ua_s2), .trig_mag(trig.sin_mag), .neg(n_as_s2), .term(t_as)
	);

	assign valid       = v_q[NS];
	assign out_x       = x_s7;
	assign out_y       = y_s7;
	assign out_heading = head_s7;
	assign saturated   = sat_s7;

endmodule
`default_nettype wire

@@ design/planar_frame_transform.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Planar frame transform
// Moves a planar pose between a configured base frame and the world frame.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item passes through seven register stages, the last one
// feeding a skid register, before it is offered on the result channel.
// Throughput: one item per cycle, limited by the result side and by a busy trig unit.
// Reset: the valid bits, the skid register flag and the base frame clear to zero;
// the trig unit then restarts and computes sine and cosine of heading zero,
// during which no item is accepted.
// ----------------------------------------------------------------------------
module planar_frame_transform #(
	parameter int COORD_WIDTH  = pft_pkg::COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH  = pft_pkg::ANGLE_WIDTH_DEF,
	parameter int CORDIC_STEPS = pft_pkg::CORDIC_STEPS_DEF,
	localparam int CFG_DATA_WIDTH = (COORD_WIDTH > ANGLE_WIDTH - 1) ? COORD_WIDTH
		: ANGLE_WIDTH - 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	pft_in_if.sink                               pose,
	pft_out_if.source                            result,
	input  logic                                 cfg_we,
	input  logic [pft_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]            cfg_data
);
	import pft_pkg::*;

	localparam int HW = ANGLE_WIDTH - 1;

	// Base frame registers, read directly by the pipeline. The user must change
	// them only while the block holds no item; the block does not enforce it.
	logic signed [COORD_WIDTH-1:0] base_x_q;
	logic signed [COORD_WIDTH-1:0] base_y_q;
	logic signed [HW-1:0]          base_heading_q;
	logic                          heading_wr;

	pft_trig_t                     trig;

	// Pipeline and skid register.
	logic                          ce;
	logic                          accept;
	logic                          pipe_valid;
	logic signed [COORD_WIDTH-1:0] pipe_x, pipe_y;
	logic signed [ANGLE_WIDTH-1:0] pipe_heading;
	logic                          pipe_sat;

	logic                          skid_v_q;
	logic signed [COORD_WIDTH-1:0] skid_x_q, skid_y_q;
	logic signed [ANGLE_WIDTH-1:0] skid_heading_q;
	logic                          skid_sat_q;

	// ------------------------------------------------------------------
	// Configuration writes. A heading write restarts the trig unit, which
	// holds off new items until the new sine and cosine are in place.
	// ------------------------------------------------------------------
	assign heading_wr = cfg_we && (cfg_index == REG_BASE_HEADING);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_x_q       <= '0;
			base_y_q       <= '0;
			base_heading_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE_X:       base_x_q       <= cfg_data[COORD_WIDTH-1:0];
				REG_BASE_Y:       base_y_q       <= cfg_data[COORD_WIDTH-1:0];
				REG_BASE_HEADING: base_heading_q <= cfg_data[HW-1:0];
				default:          base_x_q       <= base_x_q;
			endcase
		end
	end

	pft_sincos #(
		.ANGLE_WIDTH (ANGLE_WIDTH),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_sincos (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (heading_wr),
		.heading(base_heading_q),
		.trig   (trig)
	);

	// ------------------------------------------------------------------
	// Flow control. The whole pipeline moves while the skid register is
	// empty. An item that reaches the last stage and is not taken drops
	// into the skid register, so nothing is lost when the pipeline moves
	// on; while the skid register holds an item the pipeline stands still.
	// Input ready comes from registers only.
	// ------------------------------------------------------------------
	assign ce         = !skid_v_q;
	assign pose.ready = ce && trig.ready;
	assign accept     = pose.valid && pose.ready;

	pft_datapath #(
		.COORD_WIDTH(COORD_WIDTH),
		.ANGLE_WIDTH(ANGLE_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ce          (ce),
		.accept      (accept),
		.cmd         (pose.cmd),
		.in_x        (pose.in_x),
		.in_y        (pose.in_y),
		.in_heading  (pose.in_heading),
		.base_x      (base_x_q),
		.base_y      (base_y_q),
		.base_heading(base_heading_q),
		.trig        (trig),
		.valid       (pipe_valid),
		.out_x       (pipe_x),
		.out_y       (pipe_y),
		.out_heading (pipe_heading),
		.saturated   (pipe_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (result.ready) skid_v_q <= 1'b0;
		end else if (pipe_valid && !result.ready) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			skid_x_q       <= pipe_x;
			skid_y_q       <= pipe_y;
			skid_heading_q <= pipe_heading;
			skid_sat_q     <= pipe_sat;
		end
	end

	// The skid register, when full, always holds the older item.
	assign result.valid       = skid_v_q || pipe_valid;
	assign result.out_x       = skid_v_q ? skid_x_q : pipe_x;
	assign result.out_y       = skid_v_q ? skid_y_q : pipe_y;
	assign result.out_heading = skid_v_q ? skid_heading_q : pipe_heading;
	assign result.saturated   = skid_v_q ? skid_sat_q : pipe_sat;

endmodule
`default_nettype wire

@@ design/pft_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Planar frame transform checker
// Port-level properties of the transform, attached to the top level by bind.
// ----------------------------------------------------------------------------
module pft_checker #(
	parameter int COORD_WIDTH = pft_pkg::COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH = pft_pkg::ANGLE_WIDTH_DEF
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [COORD_WIDTH-1:0]       out_x,
	input logic signed [COORD_WIDTH-1:0]       out_y,
	input logic signed [ANGLE_WIDTH-1:0]       out_heading,
	input logic                                out_saturated,
	input logic                                cfg_we,
	input logic [pft_pkg::CFG_INDEX_WIDTH-1:0] cfg_index
);
	import pft_pkg::*;

	localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

	// A result that is not taken stays offered unchanged.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
			&& $stable(out_heading) && $stable(out_saturated))
	else $error("result changed while stalled");

	// A clipped result sits on a range limit in x or y.
	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_saturated |-> (out_x == C_MAX) || (out_x == C_MIN)
			|| (out_y == C_MAX) || (out_y == C_MIN))
	else $error("saturated flag without a clipped coordinate");

	// A heading write restarts the trig unit; no item may slip in while it works.
	a_heading_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index == REG_BASE_HEADING) |=> !in_ready ##1 !in_ready)
	else $error("item accepted while the trig unit was busy");

endmodule

bind planar_frame_transform pft_checker #(
	.COORD_WIDTH(COORD_WIDTH),
	.ANGLE_WIDTH(ANGLE_WIDTH)
) u_pft_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (pose.ready),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.out_x        (result.out_x),
	.out_y        (result.out_y),
	.out_heading  (result.out_heading),
	.out_saturated(result.saturated),
	.cfg_we       (cfg_we),
	.cfg_index    (cfg_index)
);
`default_nettype wire

@@ bench/planar_frame_transform_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Planar frame transform testbench
// Streams poses through the block under a series of base frames and checks
// every returned pose against a bit-exact CORDIC-based transform written
// here, with random gaps on the pose side and stalls on the result side.
// ----------------------------------------------------------------------------
module planar_frame_transform_tb;
	import pft_pkg::*;

	localparam int CW    = COORD_WIDTH_DEF;
	localparam int AW    = ANGLE_WIDTH_DEF;
	localparam int STEPS = CORDIC_STEPS_DEF;

	localparam logic signed [CW-1:0] COORD_MAX = 32'sh7fffffff;
	localparam logic signed [CW-1:0] COORD_MIN = 32'sh80000000;

	// The block ignores writes to the one index past the heading register.
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE = 2'd3;

	// Pipeline depth plus margin, used for the settling pauses.
	localparam int SETTLE_CYCLES = 16;
	localparam int STALL_LIMIT   = 4000;
	localparam int PHASES        = 8;
	localparam int PHASE_POSES   = 116;

	// Angles in radians times 2^30 and the arctangent table of the CORDIC.
	localparam longint PI_Q30      = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint TWO_PI_Q30  = 64'sd6746518852;
	localparam longint GAIN_Q30    = 64'sd652032874;
	localparam int     ARCTAN_LEN  = 24;
	localparam longint ARCTAN_Q30 [ARCTAN_LEN] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
		131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128
	};

	typedef enum logic {TO_WORLD = 1'b0, TO_LOCAL = 1'b1} pose_cmd_t;
	typedef enum logic {ROW_POSE, ROW_FRAME} row_kind_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [AW-1:0] heading;
		logic                 saturated;
	} pose_t;

	// A directed row either sends one pose or installs a new base frame, in
	// which case x, y and heading are the frame's origin and heading.
	typedef struct packed {
		row_kind_t            kind;
		pose_cmd_t            cmd;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [AW-2:0] heading;
		logic                 known;
		pose_t                res;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 24;

	// Rows marked known carry a result that can be read straight off the
	// arithmetic: zero offsets after reset, or a pose sitting exactly on the
	// base origin. Every other row is checked against transform_pose.
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{ROW_POSE,  TO_WORLD, 0, 0, 0,       1'b1, '{0, 0, 0, 1'b0}},
		'{ROW_POSE,  TO_WORLD, 0, 0, 51472,   1'b1, '{0, 0, 51472, 1'b0}},
		'{ROW_POSE,  TO_LOCAL, 0, 0, -51472,  1'b1, '{0, 0, -51472, 1'b0}},
		'{ROW_POSE,  TO_WORLD, 0, 0, -65536,  1'b1, '{0, 0, -65536, 1'b0}},
		'{ROW_POSE,  TO_LOCAL, 0, 0, 65535,   1'b1, '{0, 0, 65535, 1'b0}},
		'{ROW_POSE,  TO_WORLD, COORD_MAX, COORD_MAX, 0, 1'b0, '0},
		'{ROW_POSE,  TO_LOCAL, COORD_MIN, COORD_MIN, 0, 1'b0, '0},
		'{ROW_POSE,  TO_WORLD, 1, -1, 1,      1'b0, '0},
		'{ROW_POSE,  TO_LOCAL, 65536, -65536, -1, 1'b0, '0},
		'{ROW_FRAME, TO_WORLD, COORD_MAX, COORD_MIN, 51472, 1'b0, '0},
		'{ROW_POSE,  TO_WORLD, 0, 0, 0,       1'b1, '{COORD_MAX, COORD_MIN, 51472, 1'b0}},
		'{ROW_POSE,  TO_WORLD, COORD_MAX, 0, 0, 1'b0, '0},
		'{ROW_POSE,  TO_LOCAL, COORD_MAX, COORD_MIN, -51472, 1'b1, '{0, 0, -102944, 1'b0}},
		'{ROW_POSE,  TO_LOCAL, COORD_MIN, COORD_MAX, 51472, 1'b0, '0},
		'{ROW_FRAME, TO_WORLD, COORD_MIN, COORD_MAX, -51472, 1'b0, '0},
		'{ROW_POSE,  TO_WORLD, 0, 0, -51472,  1'b1, '{COORD_MIN, COORD_MAX, -102944, 1'b0}},
		'{ROW_POSE,  TO_LOCAL, COORD_MIN, COORD_MAX, 51472, 1'b1, '{0, 0, 102944, 1'b0}},
		'{ROW_POSE,  TO_WORLD, COORD_MIN, COORD_MIN, 0, 1'b0, '0},
		'{ROW_POSE,  TO_LOCAL, COORD_MAX, COORD_MIN, 0, 1'b0, '0},
		'{ROW_FRAME, TO_WORLD, 0, 0, -65536,  1'b0, '0},
		'{ROW_POSE,  TO_WORLD, 65536, 0, 0,   1'b0, '0},
		'{ROW_POSE,  TO_LOCAL, 0, 65536, -65536, 1'b0, '0},
		'{ROW_FRAME, TO_WORLD, 0, 0, 25736,   1'b0, '0},
		'{ROW_POSE,  TO_WORLD, 65536, 65536, 0, 1'b0, '0}
	};

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [CW-1:0]              cfg_data;

	pft_in_if  #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) pose_ch ();
	pft_out_if #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) result_ch ();

	planar_frame_transform DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.pose      (pose_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Our copy of the base frame, updated whenever the registers are written.
	logic signed [CW-1:0] frame_x       = '0;
	logic signed [CW-1:0] frame_y       = '0;
	logic signed [AW-2:0] frame_heading = '0;

	// Poses in flight, oldest first, as they should come back.
	pose_t transformed_poses [$];

	// Percent chance per cycle of a gap on the pose side or a stall on the
	// result side; changed only between phases.
	int  gap_pct   = 0;
	int  stall_pct = 0;
	bit  failed    = 1'b0;
	int  poses_sent;
	int  world_bound;
	int  poses_returned;
	int  clipped_count;
	int  frames_loaded;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Transform arithmetic
	// ------------------------------------------------------------------------

	// Product of a coordinate and a Q30 trig value, rounded half away from
	// zero to the coordinate's own scale. The operand is split so that no
	// partial product leaves 64 bits.
	function automatic longint round_q30(input longint a, input longint b);
		bit                neg;
		longint unsigned   ua;
		longint unsigned   ub;
		longint unsigned   q;
		neg = (a < 0) != (b < 0);
		ua  = (a < 0) ? -a : a;
		ub  = (b < 0) ? -b : b;
		q   = (ua >> 30) * ub + (((ua & 64'h3fffffff) * ub + 64'h20000000) >> 30);
		return neg ? -longint'(q) : longint'(q);
	endfunction

	// Cosine and sine of the base heading in Q30. The angle is first folded
	// into [-pi/2, pi/2]; folding by pi flips the sign of both results.
	function automatic void heading_sincos(input longint h, output longint c,
			output longint s);
		longint z;
		longint x;
		longint y;
		longint dx;
		longint dy;
		bit     flip;
		z    = (h * 65536) % TWO_PI_Q30;
		x    = GAIN_Q30;
		y    = 0;
		flip = 1'b0;
		if (z > PI_Q30) z -= TWO_PI_Q30;
		if (z < -PI_Q30) z += TWO_PI_Q30;
		if (z > HALF_PI_Q30) begin
			z -= PI_Q30;
			flip = 1'b1;
		end else if (z < -HALF_PI_Q30) begin
			z += PI_Q30;
			flip = 1'b1;
		end
		for (int i = 0; i < STEPS && i < ARCTAN_LEN; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= ARCTAN_Q30[i];
			end else begin
				x += dx;
				y -= dy;
				z += ARCTAN_Q30[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint clip_coord(input longint v, inout logic hit);
		if (v > longint'(COORD_MAX)) begin
			hit = 1'b1;
			return longint'(COORD_MAX);
		end
		if (v < longint'(COORD_MIN)) begin
			hit = 1'b1;
			return longint'(COORD_MIN);
		end
		return v;
	endfunction

	// Pose as the block should return it under the current base frame.
	function automatic pose_t transform_pose(input pose_cmd_t cmd,
			input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
			input logic signed [AW-2:0] h);
		longint px;
		longint py;
		longint bx;
		longint by;
		longint c;
		longint s;
		longint rx;
		longint ry;
		longint rh;
		pose_t  r;
		px = x;
		py = y;
		bx = frame_x;
		by = frame_y;
		heading_sincos(longint'(frame_heading), c, s);
		if (cmd == TO_WORLD) begin
			rx = bx + round_q30(px, c) - round_q30(py, s);
			ry = by + round_q30(px, s) + round_q30(py, c);
			rh = longint'(frame_heading) + longint'(h);
		end else begin
			rx = round_q30(px - bx, c) + round_q30(py - by, s);
			ry = round_q30(py - by, c) - round_q30(px - bx, s);
			rh = longint'(h) - longint'(frame_heading);
		end
		r.saturated = 1'b0;
		rx          = clip_coord(rx, r.saturated);
		ry          = clip_coord(ry, r.saturated);
		r.x         = rx[CW-1:0];
		r.y         = ry[CW-1:0];
		r.heading   = rh[AW-1:0];
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Random fields
	// ------------------------------------------------------------------------

	// Mostly coordinates within a few tens of meters, where nothing clips,
	// with full-range values and the extremes mixed in.
	function automatic logic signed [CW-1:0] random_coord();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(4))
					0: return COORD_MAX;
					1: return COORD_MIN;
					2: return '0;
					3: return -1;
					default: return 1;
				endcase
			end
			1, 2, 3: return $urandom;
			default: return $signed($urandom_range(32'd8388608)) - 32'sd4194304;
		endcase
	endfunction

	// Headings within plus or minus pi, with now and then any bit pattern
	// at all, since the block accepts headings out of that range.
	function automatic logic signed [AW-2:0] random_heading();
		if ($urandom_range(9) == 0)
			return (AW-1)'($urandom);
		return (AW-1)'($signed($urandom_range(32'd102944)) - 32'sd51472);
	endfunction

	// ------------------------------------------------------------------------
	// Pose side
	// ------------------------------------------------------------------------

	// Offers one pose and returns at the edge where it is taken. The caller
	// leaves valid high when the next pose follows at once, so a back-to-back
	// stream never sees valid dropped and raised in the same step.
	task automatic send_pose(input pose_cmd_t cmd, input logic signed [CW-1:0] x,
			input logic signed [CW-1:0] y, input logic signed [AW-2:0] h);
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			pose_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		pose_ch.valid      <= 1'b1;
		pose_ch.cmd        <= cmd;
		pose_ch.in_x       <= x;
		pose_ch.in_y       <= y;
		pose_ch.in_heading <= h;
		do @(posedge clk); while (!pose_ch.ready);
		poses_sent++;
		if (cmd == TO_WORLD) world_bound++;
	endtask

	// Holds the pose side idle until every pose in flight has come back.
	task automatic wait_for_results();
		pose_ch.valid <= 1'b0;
		do @(posedge clk); while (transformed_poses.size() != 0);
	endtask

	// Installs a new base frame once the pipeline is empty. The spare index
	// gets a write of noise, which the block must ignore.
	task automatic load_frame(input logic signed [CW-1:0] bx,
			input logic signed [CW-1:0] by, input logic signed [AW-2:0] bh);
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_BASE_X;
		cfg_data  <= bx;
		@(posedge clk);
		cfg_index <= REG_BASE_Y;
		cfg_data  <= by;
		@(posedge clk);
		cfg_index <= REG_BASE_HEADING;
		cfg_data  <= CW'(bh);
		@(posedge clk);
		cfg_index <= REG_SPARE;
		cfg_data  <= $urandom;
		@(posedge clk);
		cfg_we        <= 1'b0;
		frame_x       = bx;
		frame_y       = by;
		frame_heading = bh;
		frames_loaded++;
	endtask

	// ------------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------------

	task automatic check_result();
		pose_t want;
		if (transformed_poses.size() == 0) begin
			$error("result arrived with no pose in flight: x %0d y %0d heading %0d",
				result_ch.out_x, result_ch.out_y, result_ch.out_heading);
			failed = 1'b1;
			return;
		end
		want = transformed_poses.pop_front();
		poses_returned++;
		if (result_ch.saturated) clipped_count++;
		if (result_ch.out_x !== want.x) begin
			$error("out_x: expected %0d, got %0d", want.x, result_ch.out_x);
			failed = 1'b1;
		end
		if (result_ch.out_y !== want.y) begin
			$error("out_y: expected %0d, got %0d", want.y, result_ch.out_y);
			failed = 1'b1;
		end
		if (result_ch.out_heading !== want.heading) begin
			$error("out_heading: expected %0d, got %0d", want.heading,
				result_ch.out_heading);
			failed = 1'b1;
		end
		if (result_ch.saturated !== want.saturated) begin
			$error("saturated: expected %0d, got %0d", want.saturated,
				result_ch.saturated);
			failed = 1'b1;
		end
	endtask

	// Outputs are read right after the edge, before any of this step's
	// nonblocking updates land, so they hold the values seen at the edge.
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) check_result();
			result_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
		end
	end

	// The run is declared hung after a long stretch in which neither channel
	// moves an item. The limit covers the trig recompute after reset and after
	// each heading write many times over, as well as the longest random stalls.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((pose_ch.valid && pose_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("No item moved for %0d cycles, %0d poses still in flight.",
			STALL_LIMIT, transformed_poses.size());
		$display("FAILED: results differ");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------

	initial begin
		pose_cmd_t            cmd;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [AW-2:0] h;

		poses_sent     = 0;
		world_bound    = 0;
		poses_returned = 0;
		clipped_count  = 0;
		frames_loaded  = 0;

		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= REG_BASE_X;
		cfg_data           <= '0;
		pose_ch.valid      <= 1'b0;
		pose_ch.cmd        <= TO_WORLD;
		pose_ch.in_x       <= '0;
		pose_ch.in_y       <= '0;
		pose_ch.in_heading <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed rows first, under the reset frame, then under frames at the
		// corners of the coordinate and heading ranges and one at heading pi/2.
		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].kind == ROW_FRAME) begin
				load_frame(DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].heading);
			end else begin
				send_pose(DIRECTED[i].cmd, DIRECTED[i].x, DIRECTED[i].y,
					DIRECTED[i].heading);
				transformed_poses.push_back(DIRECTED[i].known ? DIRECTED[i].res
					: transform_pose(DIRECTED[i].cmd, DIRECTED[i].x, DIRECTED[i].y,
					DIRECTED[i].heading));
			end
		end

		// Random phases. Each starts with a fresh base frame: back at zero,
		// at both corners of the range, with headings beyond plus or minus
		// pi, then fully random frames. The idling pattern cycles through a
		// clean stream, sparse poses, a slow receiver and both at once.
		for (int p = 0; p < PHASES; p++) begin
			gap_pct   = 0;
			stall_pct = 0;
			case (p)
				0: load_frame('0, '0, '0);
				1: load_frame(COORD_MAX, COORD_MAX, 51472);
				2: load_frame(COORD_MIN, COORD_MIN, -51472);
				3: load_frame(random_coord(), random_coord(), 65535);
				4: load_frame(random_coord(), random_coord(), -65536);
				default: load_frame(random_coord(), random_coord(), random_heading());
			endcase
			case (p % 4)
				1: gap_pct = 70;
				2: stall_pct = 70;
				3: begin
					gap_pct   = 34;
					stall_pct = 34;
				end
				default: ;
			endcase
			for (int n = 0; n < PHASE_POSES; n++) begin
				// Once in the run the pose side holds off mid-stream until the
				// pipeline has fully drained, then picks up again.
				if (p == 6 && n == PHASE_POSES / 2) wait_for_results();
				cmd = pose_cmd_t'($urandom_range(1));
				x   = random_coord();
				y   = random_coord();
				h   = random_heading();
				send_pose(cmd, x, y, h);
				transformed_poses.push_back(transform_pose(cmd, x, y, h));
			end
		end

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d poses (%0d to world, %0d to local) under %0d base frames.",
			poses_sent, world_bound, poses_sent - world_bound, frames_loaded);
		$display("Checked %0d results, %0d of them clipped to the coordinate range.",
			poses_returned, clipped_count);
		if (!failed) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
